// ===== design/stu_pkg.sv =====
package stu_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned RadixW   = 6;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CntOutW  = 11;
  localparam int unsigned ProdW    = ValW + RadixW;

  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [RadixW-1:0] BaseOct  = 6'd8;
  localparam logic [RadixW-1:0] BaseDec  = 6'd10;
  localparam logic [RadixW-1:0] BaseHex  = 6'd16;
  localparam logic [RadixW-1:0] BaseAuto = 6'd0;

  localparam logic [ChW-1:0] ChNul    = 8'h00;
  localparam logic [ChW-1:0] ChTab    = 8'h09;
  localparam logic [ChW-1:0] ChCr     = 8'h0d;
  localparam logic [ChW-1:0] ChSpace  = 8'h20;
  localparam logic [ChW-1:0] ChPlus   = 8'h2b;
  localparam logic [ChW-1:0] ChMinus  = 8'h2d;
  localparam logic [ChW-1:0] ChZero   = 8'h30;
  localparam logic [ChW-1:0] ChNine   = 8'h39;
  localparam logic [ChW-1:0] ChUpA    = 8'h41;
  localparam logic [ChW-1:0] ChUpX    = 8'h58;
  localparam logic [ChW-1:0] ChLowA   = 8'h61;
  localparam logic [ChW-1:0] ChLowX   = 8'h78;
  localparam logic [ChW-1:0] NoDigit  = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WS     = 3'd1,
    PH_SIGN1  = 3'd2,
    PH_SIGN2  = 3'd3,
    PH_PREFIX = 3'd4,
    PH_ZERO   = 3'd5,
    PH_DIGITS = 3'd6
  } phase_e;

  function automatic logic [ChW-1:0] digit_of(input logic [ChW-1:0] c);
    logic [ChW-1:0] d;
    if (c >= ChLowA) begin
      d = c - ChLowA + 8'd10;
    end else if (c >= ChUpA) begin
      d = c - ChUpA + 8'd10;
    end else if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else begin
      d = NoDigit;
    end
    return d;
  endfunction

endpackage

// ===== design/stu_if.sv =====
interface stu_in_if;
  import stu_pkg::*;

  logic              valid;
  logic              ready;
  logic [ChW-1:0]    ch;
  logic              start_req;
  logic [RadixW-1:0] radix;

  modport source (output valid, ch, start_req, radix, input ready);
  modport sink (input valid, ch, start_req, radix, output ready);
endinterface

interface stu_out_if;
  import stu_pkg::*;

  logic               valid;
  logic               ready;
  logic [ValW-1:0]    value;
  logic [CntOutW-1:0] consumed;
  logic               overflow;

  modport source (output valid, value, consumed, overflow, input ready);
  modport sink (input valid, value, consumed, overflow, output ready);
endinterface

// ===== design/string_to_unsigned_parser.sv =====
// Streaming string-to-unsigned parser, one character per request.
// The result is registered and presented in the cycle after its terminating character is accepted.
// Throughput: one character per cycle unless a held result stalls input; the whole parse step is one 32x6 multiply-add.
// A result held back by the receiver stalls input until it is taken.
// Reset (rst_ni low, asynchronous) returns the parser to idle with no result pending.
module string_to_unsigned_parser #(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stu_in_if.sink           req_i,
  stu_out_if.source        res_o
);
  import stu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CHARS);

  phase_e            ph_q, ph_d;
  logic              neg_q, neg_d;
  logic [RadixW-1:0] base_q, base_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              emit;
  logic              held;
  logic [CntW-1:0]   cnt_bump;
  logic [ChW-1:0]    dig;
  logic [ProdW-1:0]  prod;
  logic              req_acc;

  logic               res_vld_q;
  logic [ValW-1:0]    res_val_q, res_val_d;
  logic [CntOutW-1:0] res_cnt_q, res_cnt_d;
  logic               res_ovf_q, res_ovf_d;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = !res_vld_q || res_o.ready;
  assign dig         = digit_of(req_i.ch);

  // Next state: phases fall through within one character
  always_comb begin : next_state
    ph_d     = ph_q;
    neg_d    = neg_q;
    base_d   = base_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    emit     = 1'b0;
    held     = 1'b0;
    prod     = '0;
    if (req_i.start_req) begin
      ph_d   = PH_WS;
      neg_d  = 1'b0;
      base_d = (req_i.radix > RadixMax) ? RadixMax : req_i.radix;
      acc_d  = '0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end
    cnt_bump = (cnt_d < CntMax) ? cnt_d + CntW'(1) : cnt_d;
    if (ph_d == PH_IDLE) begin
      held = 1'b1;
    end
    if (!held && ph_d == PH_WS) begin
      if (req_i.ch inside {[ChTab:ChCr], ChSpace}) begin
        cnt_d = cnt_bump;
        held  = 1'b1;
      end else begin
        ph_d = PH_SIGN1;
      end
    end
    if (!held && ph_d == PH_SIGN1) begin
      ph_d = PH_SIGN2;
      if (req_i.ch == ChMinus) begin
        neg_d = 1'b1;
        cnt_d = cnt_bump;
        held  = 1'b1;
      end
    end
    if (!held && ph_d == PH_SIGN2) begin
      ph_d = PH_PREFIX;
      if (req_i.ch == ChPlus) begin
        cnt_d = cnt_bump;
        held  = 1'b1;
      end
    end
    if (!held && ph_d == PH_PREFIX) begin
      if (req_i.ch == ChZero && (base_d == BaseAuto || base_d == BaseHex)) begin
        if (base_d == BaseAuto) begin
          base_d = BaseOct;
        end
        cnt_d = cnt_bump;
        ph_d  = PH_ZERO;
        held  = 1'b1;
      end else begin
        if (base_d == BaseAuto) begin
          base_d = BaseDec;
        end
        ph_d = PH_DIGITS;
      end
    end
    if (!held && ph_d == PH_ZERO) begin
      ph_d = PH_DIGITS;
      if (req_i.ch == ChLowX || req_i.ch == ChUpX) begin
        base_d = BaseHex;
        cnt_d  = cnt_bump;
        held   = 1'b1;
      end
    end
    if (!held && ph_d == PH_DIGITS) begin
      if (req_i.ch != ChNul && dig < ChW'(base_d)) begin
        prod = ProdW'(acc_d) * ProdW'(base_d) + ProdW'(dig);
        if (prod[ProdW-1:ValW] != '0) begin
          ovf_d = 1'b1;
          acc_d = '1;
        end else if (!ovf_d) begin
          acc_d = prod[ValW-1:0];
        end
        cnt_d = cnt_bump;
      end else begin
        emit = 1'b1;
        ph_d = PH_IDLE;
      end
    end
  end

  // Result payload
  always_comb begin : result
    if (ovf_d) begin
      res_val_d = '1;
    end else if (neg_d) begin
      res_val_d = '0 - acc_d;
    end else begin
      res_val_d = acc_d;
    end
    res_cnt_d = CntOutW'(cnt_d);
    res_ovf_d = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      neg_q  <= 1'b0;
      base_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (req_acc) begin
      ph_q   <= ph_d;
      neg_q  <= neg_d;
      base_q <= base_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      res_vld_q <= req_acc && emit;
    end
  end

  // Hold payload until the next result is produced
  always_ff @(posedge clk_i) begin
    if (req_acc && emit) begin
      res_val_q <= res_val_d;
      res_cnt_q <= res_cnt_d;
      res_ovf_q <= res_ovf_d;
    end
  end

  assign res_o.valid    = res_vld_q;
  assign res_o.value    = res_val_q;
  assign res_o.consumed = res_cnt_q;
  assign res_o.overflow = res_ovf_q;

`ifndef SYNTHESIS
  a_res_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(req_acc))
    else $error("result raised without an accepted request");

  a_ovf_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_ovf_q |-> res_val_q == '1)
    else $error("overflow result is not all ones");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && emit |=> ph_q == PH_IDLE && res_vld_q)
    else $error("parser not idle after emitting a result");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("character count beyond limit");

  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= RadixMax)
    else $error("base out of range");
`endif

endmodule
